FILE: rtl/swept_box_time_of_impact_top_defines.svh
// assertion macros shared by the rtl
`ifndef SWEPT_BOX_TIME_OF_IMPACT_TOP_DEFINES_SVH
`define SWEPT_BOX_TIME_OF_IMPACT_TOP_DEFINES_SVH

// same-cycle implication
`define STOI_ASSERT_NOW(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define STOI_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: rtl/stoi_pkg.sv
`default_nettype none
package stoi_pkg;

    localparam int NUM_SIDES = 4;
    localparam int TIME_W    = 16;
    localparam int MAG_W     = 63;
    localparam logic [31:0] FRAME_TIME_RESET = 32'd1092;

    // side lanes
    localparam int SIDE_TOP    = 0;
    localparam int SIDE_BOTTOM = 1;
    localparam int SIDE_LEFT   = 2;
    localparam int SIDE_RIGHT  = 3;

    // input word, mover_left in the lowest bits, pad in the highest
    typedef struct packed {
        logic [3:0]         pad;
        logic [30:0]        fixed_height;
        logic [30:0]        fixed_width;
        logic signed [31:0] fixed_top;
        logic signed [31:0] fixed_left;
        logic signed [31:0] speed_y;
        logic signed [31:0] speed_x;
        logic [30:0]        mover_height;
        logic [30:0]        mover_width;
        logic signed [31:0] mover_top;
        logic signed [31:0] mover_left;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] ml;
        logic signed [31:0] mt;
        logic [30:0]        mw;
        logic [30:0]        mh;
        logic signed [31:0] fl;
        logic signed [31:0] ft;
        logic [30:0]        fw;
        logic [30:0]        fh;
    } box_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } travel_t;

    typedef struct packed {
        logic              ok;
        logic [MAG_W-1:0]  r;
        logic [TIME_W-1:0] q;
    } lane_t;

    typedef struct packed {
        box_t                       box;
        travel_t                    tx;
        travel_t                    ty;
        lane_t [NUM_SIDES-1:0]      lane;
    } div_word_t;

    typedef struct packed {
        logic [NUM_SIDES-1:0]             hit;
        logic [NUM_SIDES-1:0][TIME_W-1:0] tm;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/stoi_div_cell.sv
`default_nettype none
module stoi_div_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire stoi_pkg::div_word_t in_word,
    output logic                     out_valid,
    output stoi_pkg::div_word_t      out_word
);
    import stoi_pkg::*;

    logic      valid_reg;
    div_word_t word_reg;
    div_word_t word_next;

    // one restoring quotient bit per side lane
    always_comb begin
        logic [MAG_W-1:0] dm;
        logic [MAG_W:0]   rs;
        logic             ge;
        word_next = in_word;
        for (int l = 0; l < NUM_SIDES; l++) begin
            dm = (l < SIDE_LEFT) ? in_word.ty.mag : in_word.tx.mag;
            rs = {in_word.lane[l].r, 1'b0};
            ge = (rs >= {1'b0, dm});
            word_next.lane[l].r = ge ? MAG_W'(rs - {1'b0, dm}) : rs[MAG_W-1:0];
            word_next.lane[l].q = {in_word.lane[l].q[TIME_W-2:0], ge};
        end
    end

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
endmodule
`default_nettype wire

FILE: rtl/stoi_resolve.sv
`default_nettype none
module stoi_resolve (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire stoi_pkg::div_word_t in_word,
    output logic                     out_valid,
    output stoi_pkg::result_t        out_result
);
    import stoi_pkg::*;

    // stage 1: partial products of time and other-axis travel
    logic                             v1_reg;
    box_t                             box1_reg;
    logic [NUM_SIDES-1:0]             ok1_reg;
    logic [NUM_SIDES-1:0]             neg1_reg;
    logic [NUM_SIDES-1:0][TIME_W-1:0] t1_reg;
    logic [NUM_SIDES-1:0][47:0]       lo1_reg;
    logic [NUM_SIDES-1:0][46:0]       hi1_reg;
    logic [NUM_SIDES-1:0][47:0]       lo1_next;
    logic [NUM_SIDES-1:0][46:0]       hi1_next;
    logic [NUM_SIDES-1:0]             neg1_next;

    always_comb begin
        travel_t ot;
        for (int l = 0; l < NUM_SIDES; l++) begin
            ot = (l < SIDE_LEFT) ? in_word.tx : in_word.ty;
            lo1_next[l]  = {32'd0, in_word.lane[l].q} * {16'd0, ot.mag[31:0]};
            hi1_next[l]  = {31'd0, in_word.lane[l].q} * {16'd0, ot.mag[MAG_W-1:32]};
            neg1_next[l] = ot.neg;
        end
    end

    // stage 2: moved position on the other axis
    logic                             v2_reg;
    box_t                             box2_reg;
    logic [NUM_SIDES-1:0]             ok2_reg;
    logic [NUM_SIDES-1:0][TIME_W-1:0] t2_reg;
    logic [NUM_SIDES-1:0][49:0]       pos2_reg;
    logic [NUM_SIDES-1:0][49:0]       pos2_next;

    always_comb begin
        logic [47:0]        m;
        logic signed [48:0] s;
        logic signed [49:0] a0;
        for (int l = 0; l < NUM_SIDES; l++) begin
            m  = hi1_reg[l] + {32'd0, lo1_reg[l][47:32]};
            s  = neg1_reg[l] ? -$signed({1'b0, m}) : $signed({1'b0, m});
            a0 = (l < SIDE_LEFT) ? {{18{box1_reg.ml[31]}}, box1_reg.ml}
                                 : {{18{box1_reg.mt[31]}}, box1_reg.mt};
            pos2_next[l] = a0 + {s[48], s};
        end
    end

    // stage 3: inclusive overlap test
    logic    v3_reg;
    result_t res3_reg;
    result_t res3_next;

    always_comb begin
        logic signed [49:0] pos;
        logic signed [49:0] b0;
        logic signed [49:0] lim;
        logic signed [49:0] fin;
        logic               hit;
        for (int l = 0; l < NUM_SIDES; l++) begin
            pos = $signed(pos2_reg[l]);
            if (l < SIDE_LEFT) begin
                b0  = {{18{box2_reg.fl[31]}}, box2_reg.fl};
                lim = b0 + $signed({19'd0, box2_reg.fw});
                fin = pos + $signed({19'd0, box2_reg.mw});
            end else begin
                b0  = {{18{box2_reg.ft[31]}}, box2_reg.ft};
                lim = b0 + $signed({19'd0, box2_reg.fh});
                fin = pos + $signed({19'd0, box2_reg.mh});
            end
            hit = ok2_reg[l] && (pos <= lim) && (fin >= b0);
            res3_next.hit[l] = hit;
            res3_next.tm[l]  = hit ? t2_reg[l] : '0;
        end
    end

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (en) begin
            box1_reg <= in_word.box;
            neg1_reg <= neg1_next;
            lo1_reg  <= lo1_next;
            hi1_reg  <= hi1_next;
            for (int l = 0; l < NUM_SIDES; l++) begin
                ok1_reg[l] <= in_word.lane[l].ok;
                t1_reg[l]  <= in_word.lane[l].q;
            end
            box2_reg <= box1_reg;
            ok2_reg  <= ok1_reg;
            t2_reg   <= t1_reg;
            pos2_reg <= pos2_next;
            res3_reg <= res3_next;
        end
    end

    assign out_valid  = v3_reg;
    assign out_result = res3_reg;
endmodule
`default_nettype wire

FILE: rtl/swept_box_time_of_impact_top.sv
// channel   dir  signals                              payload
// s_        in   s_tvalid s_tready s_tdata[319:0]     one box pair
// m_        out  m_tvalid m_tready m_tdata[71:0]      four side hits and times
// cfg_      in   cfg_valid cfg_ready cfg_data[31:0]   frame_time
//
// one word accepted per cycle while s_tready is high, that is while the skid register is empty
// the pipeline holds a chain of 16 quotient cells, one bit per cell
// a skid register at the output lets the pipeline hold while m_tready is low
// aresetn (synchronous) empties the pipeline and sets frame_time to 1092
`default_nettype none
`include "swept_box_time_of_impact_top_defines.svh"
module swept_box_time_of_impact_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // mover_left, mover_top, mover_width, mover_height, speed_x, speed_y,
    // fixed_left, fixed_top, fixed_width, fixed_height, 4 zero bits
    input  wire logic [319:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // hit_top_side, time_top_side, hit_bottom_side, time_bottom_side,
    // hit_left_side, time_left_side, hit_right_side, time_right_side, 4 zero bits
    output logic [71:0]       m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [31:0]  cfg_data
);
    import stoi_pkg::*;

    localparam int NUM_CELLS = TIME_W;

    logic [31:0] frame_time_reg;
    logic        en;
    in_word_t    in_word;

    // frame time register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_time_reg <= FRAME_TIME_RESET;
        end else if (cfg_valid) begin
            frame_time_reg <= cfg_data;
        end
    end

    // stage a: travel products and edge gaps
    logic                     va_reg;
    box_t                     boxa_reg;
    logic signed [63:0]       pxa_reg;
    logic signed [63:0]       pya_reg;
    logic [NUM_SIDES-1:0][33:0] gapa_reg;
    logic signed [65:0]       px_full;
    logic signed [65:0]       py_full;
    logic [NUM_SIDES-1:0][33:0] gap_next;
    box_t                     box_next;

    assign in_word = in_word_t'(s_tdata);

    always_comb begin
        logic signed [32:0] ftm;
        logic signed [33:0] ml, mt, mw, mh, fl, ft, fw, fh;
        ftm     = $signed({1'b0, frame_time_reg});
        px_full = ftm * $signed({in_word.speed_x[31], in_word.speed_x});
        py_full = ftm * $signed({in_word.speed_y[31], in_word.speed_y});
        ml = {{2{in_word.mover_left[31]}}, in_word.mover_left};
        mt = {{2{in_word.mover_top[31]}}, in_word.mover_top};
        mw = {3'd0, in_word.mover_width};
        mh = {3'd0, in_word.mover_height};
        fl = {{2{in_word.fixed_left[31]}}, in_word.fixed_left};
        ft = {{2{in_word.fixed_top[31]}}, in_word.fixed_top};
        fw = {3'd0, in_word.fixed_width};
        fh = {3'd0, in_word.fixed_height};
        gap_next[SIDE_TOP]    = ft - mt - mh;
        gap_next[SIDE_BOTTOM] = ft + fh - mt;
        gap_next[SIDE_LEFT]   = fl - ml - mw;
        gap_next[SIDE_RIGHT]  = fl + fw - ml;
        box_next.ml = in_word.mover_left;
        box_next.mt = in_word.mover_top;
        box_next.mw = in_word.mover_width;
        box_next.mh = in_word.mover_height;
        box_next.fl = in_word.fixed_left;
        box_next.ft = in_word.fixed_top;
        box_next.fw = in_word.fixed_width;
        box_next.fh = in_word.fixed_height;
    end

    // stage b: magnitudes, direction and range check
    logic      vb_reg;
    div_word_t wb_reg;
    div_word_t wb_next;

    always_comb begin
        logic [63:0] pxm;
        logic [63:0] pym;
        logic [33:0] nm;
        travel_t     p;
        pxm = pxa_reg[63] ? 64'(-pxa_reg) : 64'(pxa_reg);
        pym = pya_reg[63] ? 64'(-pya_reg) : 64'(pya_reg);
        wb_next.box    = boxa_reg;
        wb_next.tx.neg = pxa_reg[63];
        wb_next.tx.mag = pxm[MAG_W-1:0];
        wb_next.ty.neg = pya_reg[63];
        wb_next.ty.mag = pym[MAG_W-1:0];
        for (int l = 0; l < NUM_SIDES; l++) begin
            p  = (l < SIDE_LEFT) ? wb_next.ty : wb_next.tx;
            nm = gapa_reg[l][33] ? 34'(-gapa_reg[l]) : gapa_reg[l];
            wb_next.lane[l].r  = {13'd0, nm[32:0], 17'd0} >> 1;
            wb_next.lane[l].q  = '0;
            wb_next.lane[l].ok = (p.mag != '0)
                && ((gapa_reg[l] == '0) || (gapa_reg[l][33] == p.neg))
                && ({14'd0, nm[32:0], 16'd0} < p.mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else if (en) begin
            va_reg <= s_tvalid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            boxa_reg <= box_next;
            pxa_reg  <= px_full[63:0];
            pya_reg  <= py_full[63:0];
            gapa_reg <= gap_next;
            wb_reg   <= wb_next;
        end
    end

    // quotient cell chain
    logic      cv   [NUM_CELLS+1];
    div_word_t cw   [NUM_CELLS+1];

    assign cv[0] = vb_reg;
    assign cw[0] = wb_reg;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        stoi_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cv[i]),
            .in_word   (cw[i]),
            .out_valid (cv[i+1]),
            .out_word  (cw[i+1])
        );
    end

    // shift along the other axis and overlap test
    logic    res_valid;
    result_t res;

    stoi_resolve u_resolve (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (cv[NUM_CELLS]),
        .in_word    (cw[NUM_CELLS]),
        .out_valid  (res_valid),
        .out_result (res)
    );

    // output register with skid
    logic    out_valid_reg;
    result_t out_reg;
    logic    skid_valid_reg;
    result_t skid_reg;
    logic    push;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign push     = en && res_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (push) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_reg.tm[SIDE_RIGHT],  out_reg.hit[SIDE_RIGHT],
                       out_reg.tm[SIDE_LEFT],   out_reg.hit[SIDE_LEFT],
                       out_reg.tm[SIDE_BOTTOM], out_reg.hit[SIDE_BOTTOM],
                       out_reg.tm[SIDE_TOP],    out_reg.hit[SIDE_TOP]};

    // checks
    `STOI_ASSERT_NOW(a_skid_implies_out, aclk, aresetn,
        skid_valid_reg, out_valid_reg, "skid holds a word while output is empty")
    `STOI_ASSERT_NEXT(a_stall_fills_skid, aclk, aresetn,
        out_valid_reg && !m_tready && push, skid_valid_reg, "stalled word was dropped")
    `STOI_ASSERT_NEXT(a_skid_drains, aclk, aresetn,
        skid_valid_reg && m_tready, !skid_valid_reg && out_valid_reg, "skid did not drain")
    `STOI_ASSERT_NOW(a_time_zero_no_hit, aclk, aresetn, out_valid_reg,
        (out_reg.hit[SIDE_TOP] || out_reg.tm[SIDE_TOP] == '0)
        && (out_reg.hit[SIDE_BOTTOM] || out_reg.tm[SIDE_BOTTOM] == '0)
        && (out_reg.hit[SIDE_LEFT] || out_reg.tm[SIDE_LEFT] == '0)
        && (out_reg.hit[SIDE_RIGHT] || out_reg.tm[SIDE_RIGHT] == '0),
        "time set on a side without a hit")
endmodule
`default_nettype wire
